[rtl/core/lttc_pkg.sv]
`timescale 1ns / 1ps

package lttc_pkg;

    localparam int ENTRIES_DEF   = 16;
    localparam int KEY_BITS_DEF  = 32;
    localparam int TIME_BITS_DEF = 48;

    localparam int CAP_W     = 5;
    localparam int TTL_W     = 32;
    localparam int CNT_W     = 32;
    localparam int OCC_OUT_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
    localparam logic [TTL_W-1:0] TTL_RESET = TTL_W'(60000);

    typedef enum logic [0:0] {
        CFG_CAPACITY = 1'b0,
        CFG_TTL      = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

    typedef struct packed {
        logic match;
        logic live;
    } cell_stat_t;

    typedef struct packed {
        logic [CNT_W-1:0]     expiration_count;
        logic [CNT_W-1:0]     eviction_count;
        logic [CNT_W-1:0]     miss_count;
        logic [CNT_W-1:0]     hit_count;
        logic [CNT_W-1:0]     total_count;
        logic [OCC_OUT_W-1:0] occupancy;
        logic                 evicted;
        logic                 expired;
        logic                 hit;
    } result_t;

    localparam int OUT_W = $bits(result_t);

endpackage

[rtl/core/lru_ttl_cache_tracker.sv]
`timescale 1ns / 1ps

// LRU key tracker with sliding time-to-live.
// Input stream s_axis carries one access (key, now_ms) per transfer; output
// stream m_axis returns one result per access: hit/expired/evicted flags,
// occupancy after the access and five saturating counters.
// Entries sit in a chain of cells ordered by recency, most recent in cell 0.
// An access is looked up in all cells at once and the chain updates at the
// accepting edge: entries ahead of the hit move one cell back and the key
// lands in cell 0; on eviction the last live cell is dropped.
// The result is registered at the input transfer; throughput is one access
// per cycle unless the output stalls, set by the single lookup-and-shift step.
// A stalled result holds the output register and the input is held off while
// it waits; a new access is taken in the same cycle the result is taken.
// Reset empties every cell, clears all counters, sets capacity to 16 and
// ttl_ms to 60000. cfg_we writes capacity (index 0) or ttl_ms (index 1).
module lru_ttl_cache_tracker #(
    parameter int ENTRIES   = lttc_pkg::ENTRIES_DEF,
    parameter int KEY_BITS  = lttc_pkg::KEY_BITS_DEF,
    parameter int TIME_BITS = lttc_pkg::TIME_BITS_DEF,
    localparam int IN_W     = ((KEY_BITS + TIME_BITS + 7) / 8) * 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [0:0]                  cfg_addr,
    input  logic [lttc_pkg::TTL_W-1:0]  cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // key, now_ms, zero fill
    input  logic [IN_W-1:0]             s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // hit, expired, evicted, occupancy, total_count, hit_count, miss_count,
    // eviction_count, expiration_count
    output logic [lttc_pkg::OUT_W-1:0]  m_axis_tdata
);

    localparam int EXP_W = ((TIME_BITS > lttc_pkg::TTL_W) ? TIME_BITS : lttc_pkg::TTL_W) + 1;

    logic [KEY_BITS-1:0]   key;
    logic [EXP_W-1:0]      now;
    logic [EXP_W-1:0]      new_exp;
    lttc_pkg::cell_stat_t  stat [ENTRIES];
    lttc_pkg::cell_ctl_t   ctl [ENTRIES];
    lttc_pkg::result_t     result;

    logic                  chain_valid [ENTRIES+1];
    logic [KEY_BITS-1:0]   chain_key   [ENTRIES+1];
    logic [EXP_W-1:0]      chain_exp   [ENTRIES+1];

    assign key = s_axis_tdata[KEY_BITS-1:0];
    assign now = EXP_W'(s_axis_tdata[KEY_BITS +: TIME_BITS]);

    assign chain_valid[0] = 1'b1;
    assign chain_key[0]   = key;
    assign chain_exp[0]   = new_exp;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            lttc_cell #(
                .KEY_BITS (KEY_BITS),
                .EXP_W    (EXP_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .look_key   (key),
                .look_now   (now),
                .ctl        (ctl[g]),
                .prev_valid (chain_valid[g]),
                .prev_key   (chain_key[g]),
                .prev_exp   (chain_exp[g]),
                .cur_valid  (chain_valid[g+1]),
                .cur_key    (chain_key[g+1]),
                .cur_exp    (chain_exp[g+1]),
                .stat       (stat[g])
            );
        end
    endgenerate

    lttc_ctrl #(
        .ENTRIES (ENTRIES),
        .EXP_W   (EXP_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .now       (now),
        .new_exp   (new_exp),
        .stat      (stat),
        .ctl       (ctl),
        .result    (result)
    );

    assign m_axis_tdata = result;

endmodule

[rtl/core/lttc_cell.sv]
`timescale 1ns / 1ps

module lttc_cell #(
    parameter int KEY_BITS = lttc_pkg::KEY_BITS_DEF,
    parameter int EXP_W    = lttc_pkg::TIME_BITS_DEF + 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [KEY_BITS-1:0]   look_key,
    input  logic [EXP_W-1:0]      look_now,
    input  lttc_pkg::cell_ctl_t   ctl,
    input  logic                  prev_valid,
    input  logic [KEY_BITS-1:0]   prev_key,
    input  logic [EXP_W-1:0]      prev_exp,
    output logic                  cur_valid,
    output logic [KEY_BITS-1:0]   cur_key,
    output logic [EXP_W-1:0]      cur_exp,
    output lttc_pkg::cell_stat_t  stat
);

    logic                valid_reg;
    logic                valid_next;
    logic [KEY_BITS-1:0] key_reg;
    logic [EXP_W-1:0]    exp_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.shift)
        begin
            valid_next = prev_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            key_reg <= prev_key;
            exp_reg <= prev_exp;
        end
    end

    assign stat.match = valid_reg && (key_reg == look_key);
    assign stat.live  = exp_reg > look_now;

    assign cur_valid = valid_reg;
    assign cur_key   = key_reg;
    assign cur_exp   = exp_reg;

endmodule

[rtl/core/lttc_ctrl.sv]
`timescale 1ns / 1ps

module lttc_ctrl #(
    parameter int ENTRIES = lttc_pkg::ENTRIES_DEF,
    parameter int EXP_W   = lttc_pkg::TIME_BITS_DEF + 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [0:0]                  cfg_addr,
    input  logic [lttc_pkg::TTL_W-1:0]  cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    output logic                        out_valid,
    input  logic                        out_ready,
    input  logic [EXP_W-1:0]            now,
    output logic [EXP_W-1:0]            new_exp,
    input  lttc_pkg::cell_stat_t        stat [ENTRIES],
    output lttc_pkg::cell_ctl_t         ctl [ENTRIES],
    output lttc_pkg::result_t           result
);

    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (OCC_W > lttc_pkg::CAP_W) ? OCC_W : lttc_pkg::CAP_W;
    localparam int CW    = lttc_pkg::CNT_W;

    logic [lttc_pkg::CAP_W-1:0] cap_reg;
    logic [lttc_pkg::TTL_W-1:0] ttl_reg;
    logic                       out_valid_reg;
    logic [OCC_W-1:0]           occ_reg;
    logic [OCC_W-1:0]           occ_next;
    logic [CW-1:0]              total_reg;
    logic [CW-1:0]              hits_reg;
    logic [CW-1:0]              misses_reg;
    logic [CW-1:0]              evicts_reg;
    logic [CW-1:0]              expires_reg;
    logic                       hit_reg;
    logic                       expired_reg;
    logic                       evicted_reg;

    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] live_vec;
    logic [ENTRIES-1:0] at_or_above;
    logic               fire;
    logic               found;
    logic               hit;
    logic               expired;
    logic               evict;
    logic [OCC_W-1:0]   remain;
    logic [CMP_W-1:0]   cap_ext;
    logic [CMP_W-1:0]   cap_eff;

    assign in_ready  = !out_valid_reg || out_ready;
    assign fire      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign new_exp   = now + EXP_W'(ttl_reg);

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_vec
            assign match_vec[g]   = stat[g].match;
            assign live_vec[g]    = stat[g].live;
            assign at_or_above[g] = |match_vec[ENTRIES-1:g];
            assign ctl[g].shift   = fire && (!found || at_or_above[g]);
            assign ctl[g].clear   = fire && evict && (remain == OCC_W'(g));
        end
    endgenerate

    assign found   = |match_vec;
    assign hit     = |(match_vec & live_vec);
    assign expired = found && !hit;
    assign remain  = expired ? (occ_reg - OCC_W'(1)) : occ_reg;

    always_comb
    begin
        cap_ext = CMP_W'(cap_reg);
        cap_eff = cap_ext;
        if (cap_ext == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(ENTRIES))
        begin
            cap_eff = CMP_W'(ENTRIES);
        end
    end

    assign evict = !hit && (remain != '0) && (CMP_W'(remain) >= cap_eff);

    always_comb
    begin
        if (hit)
        begin
            occ_next = occ_reg;
        end
        else if (evict)
        begin
            occ_next = remain;
        end
        else
        begin
            occ_next = remain + OCC_W'(1);
        end
    end

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        sat_inc = (v == '1) ? v : v + CW'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= lttc_pkg::CAP_RESET;
            ttl_reg <= lttc_pkg::TTL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (lttc_pkg::cfg_idx_t'(cfg_addr))
                lttc_pkg::CFG_CAPACITY: cap_reg <= cfg_wdata[lttc_pkg::CAP_W-1:0];
                lttc_pkg::CFG_TTL:      ttl_reg <= cfg_wdata[lttc_pkg::TTL_W-1:0];
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            occ_reg       <= '0;
            total_reg     <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            evicts_reg    <= '0;
            expires_reg   <= '0;
        end
        else
        begin
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                occ_reg   <= occ_next;
                total_reg <= sat_inc(total_reg);
                if (hit)
                begin
                    hits_reg <= sat_inc(hits_reg);
                end
                else
                begin
                    misses_reg <= sat_inc(misses_reg);
                end
                if (evict)
                begin
                    evicts_reg <= sat_inc(evicts_reg);
                end
                if (expired)
                begin
                    expires_reg <= sat_inc(expires_reg);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            hit_reg     <= hit;
            expired_reg <= expired;
            evicted_reg <= evict;
        end
    end

    assign result.expiration_count = expires_reg;
    assign result.eviction_count   = evicts_reg;
    assign result.miss_count       = misses_reg;
    assign result.hit_count        = hits_reg;
    assign result.total_count      = total_reg;
    assign result.occupancy        = lttc_pkg::OCC_OUT_W'(occ_reg);
    assign result.evicted          = evicted_reg;
    assign result.expired          = expired_reg;
    assign result.hit              = hit_reg;

endmodule

[rtl/core/lttc_checker.sv]
`timescale 1ns / 1ps

module lttc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [lttc_pkg::OUT_W-1:0]  m_axis_tdata
);

    lttc_pkg::result_t res;

    assign res = lttc_pkg::result_t'(m_axis_tdata);

    // held result stays put under backpressure
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // every input transfer yields a result in the next cycle
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("no result after input transfer");

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(res.hit && res.expired))
        else $error("hit and expired together");

    a_hit_noevict: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.hit |-> !res.evicted && res.occupancy != '0)
        else $error("hit with eviction or empty tracker");

endmodule

bind lru_ttl_cache_tracker lttc_checker u_lttc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
